@@ hw/rtl/gsg_pkg.sv @@
// Shared types, constants and LFSR step functions for the Gold sequence generator.
package gsg_pkg;

  localparam int unsigned WARMUP_STEPS_DEFAULT = 1600;
  localparam int unsigned LFSR_W = 31;
  localparam int unsigned SHIFT_W = 17;
  localparam int unsigned PROD_W = LFSR_W - SHIFT_W;
  localparam int unsigned TERM_W = 12;
  localparam int unsigned SYMS_PER_SLOT = 14;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLING_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCID_TERM = 1'd1;
  localparam logic [2:0] SCID_TERM_RESET = 3'd5;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [15:0] QPSK_POS = 16'sd23167;
  localparam logic signed [15:0] QPSK_NEG = -16'sd23167;

  typedef struct packed {
    logic       start_req;
    logic [7:0] slot_number;
    logic [3:0] symbol_index;
  } in_t;

  typedef struct packed {
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] prod;
  } cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  function automatic logic [LFSR_W-1:0] next_one(logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[3];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  function automatic logic [LFSR_W-1:0] next_two(logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[1] ^ s[2] ^ s[3];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  function automatic logic [LFSR_W-1:0] adv_one(logic [LFSR_W-1:0] s, int unsigned n);
    logic [LFSR_W-1:0] r;
    r = s;
    for (int unsigned i = 0; i < n; i++) r = next_one(r);
    return r;
  endfunction

  function automatic logic [LFSR_W-1:0] adv_two(logic [LFSR_W-1:0] s, int unsigned n);
    logic [LFSR_W-1:0] r;
    r = s;
    for (int unsigned i = 0; i < n; i++) r = next_two(r);
    return r;
  endfunction

endpackage

@@ hw/rtl/gsg_front.sv @@
// Front end: accepts items and forms the slot/symbol product term of the initial value.
module gsg_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gsg_pkg::in_t               in_data,
  input  logic [15:0]                scrambling_id,
  input  gsg_pkg::qstat_t            q_stat,
  output logic                       q_push,
  output gsg_pkg::cmd_t              q_data
);

  logic [gsg_pkg::TERM_W-1:0]     term;
  logic [gsg_pkg::PROD_W-1:0]     nid_odd;
  logic [gsg_pkg::PROD_W-1:0]     prod_full;

  always_comb begin
    term = gsg_pkg::TERM_W'(in_data.slot_number) * gsg_pkg::TERM_W'(gsg_pkg::SYMS_PER_SLOT)
         + gsg_pkg::TERM_W'(in_data.symbol_index) + gsg_pkg::TERM_W'(1);
    nid_odd = gsg_pkg::PROD_W'({scrambling_id, 1'b1});
    prod_full = gsg_pkg::PROD_W'(term) * nid_odd;
  end

  assign in_ready = !q_stat.full;
  assign q_push = in_valid && in_ready;
  assign q_data.start = in_data.start_req;
  assign q_data.prod = prod_full;

endmodule

@@ hw/rtl/gsg_queue.sv @@
// Short command queue between front end and back end.
module gsg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gsg_pkg::cmd_t   push_data,
  input  logic            pop,
  output gsg_pkg::cmd_t   pop_data,
  output gsg_pkg::qstat_t stat
);

  gsg_pkg::cmd_t                 mem [gsg_pkg::QDEPTH];
  logic [gsg_pkg::QPTR_W-1:0]    wr_ptr;
  logic [gsg_pkg::QPTR_W-1:0]    rd_ptr;
  logic [gsg_pkg::QCNT_W-1:0]    count;

  function automatic logic [gsg_pkg::QPTR_W-1:0] wrap_inc(logic [gsg_pkg::QPTR_W-1:0] p);
    if (p == gsg_pkg::QPTR_W'(gsg_pkg::QDEPTH - 1)) return '0;
    return p + gsg_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop) count <= count + gsg_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - gsg_pkg::QCNT_W'(1);
    end
  end

  assign pop_data = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full = (count == gsg_pkg::QCNT_W'(gsg_pkg::QDEPTH));
  assign stat.count = count;

endmodule

@@ hw/rtl/gsg_back.sv @@
// Back end: loads and steps both LFSRs and registers one QPSK symbol per command.
module gsg_back #(
  parameter int unsigned WARMUP_STEPS = gsg_pkg::WARMUP_STEPS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  gsg_pkg::cmd_t q_data,
  output logic          q_pop,
  input  logic [15:0]   scrambling_id,
  input  logic [2:0]    scid_term,
  output logic          out_valid,
  input  logic          out_ready,
  output gsg_pkg::out_t out_data
);

  localparam int unsigned L = gsg_pkg::LFSR_W;
  localparam logic [L-1:0] ONE_WARM = gsg_pkg::adv_one(L'(1), WARMUP_STEPS);

  logic [L-1:0] lfsr_one;
  logic [L-1:0] lfsr_two;
  logic [L-1:0] jump_col [L];
  logic [L-1:0] cinit;
  logic [L-1:0] two_load;
  logic [L-1:0] one_cur;
  logic [L-1:0] two_cur;
  logic [L-1:0] one_next;
  logic [L-1:0] two_next;
  logic         b0;
  logic         b1;

  for (genvar j = 0; j < L; j++) begin : g_jump
    localparam logic [L-1:0] COL = gsg_pkg::adv_two(L'(1) << j, WARMUP_STEPS);
    assign jump_col[j] = COL;
  end

  always_comb begin
    cinit = {q_data.prod, gsg_pkg::SHIFT_W'(0)} + L'({scrambling_id, 1'b0}) + L'(scid_term);
    two_load = '0;
    for (int j = 0; j < L; j++) begin
      if (cinit[j]) two_load = two_load ^ jump_col[j];
    end
    one_cur = q_data.start ? ONE_WARM : lfsr_one;
    two_cur = q_data.start ? two_load : lfsr_two;
    b0 = one_cur[0] ^ two_cur[0];
    b1 = one_cur[1] ^ two_cur[1];
    one_next = gsg_pkg::next_one(gsg_pkg::next_one(one_cur));
    two_next = gsg_pkg::next_two(gsg_pkg::next_two(two_cur));
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_one <= ONE_WARM;
      lfsr_two <= '0;
      out_valid <= 1'b0;
    end else if (q_pop) begin
      lfsr_one <= one_next;
      lfsr_two <= two_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.real_part <= b0 ? gsg_pkg::QPSK_NEG : gsg_pkg::QPSK_POS;
      out_data.imag_part <= b1 ? gsg_pkg::QPSK_NEG : gsg_pkg::QPSK_POS;
    end
  end

endmodule

@@ hw/rtl/dmrs_gold_sequence_generator_unit.sv @@
// Top level of the DMRS Gold sequence generator: config registers, front end, queue, back end.
// Produces one QPSK pilot symbol (two Gold bits, +/-23167 in Q1.15) per input transfer. A start
// item reloads the first LFSR with seed 1 and the second with the initial value built from slot,
// symbol, scrambling_id and scid_term, both jumped ahead WARMUP_STEPS steps (the second by a
// constant GF(2) matrix); every item then steps both registers by two. Sustained rate is one item
// per clock while out_ready stays high, set by the back end stepping both LFSRs on every pop. With
// the queue empty and the output register free, an input item is written into the queue and then
// popped into the output register, which raises output valid. Items are taken while a result waits,
// until the two-entry queue fills. Configuration is written through cfg_we/cfg_index/cfg_data.
module dmrs_gold_sequence_generator_unit #(
  parameter int unsigned WARMUP_STEPS = gsg_pkg::WARMUP_STEPS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gsg_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsg_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [gsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0]     scrambling_id;
  logic [2:0]      scid_term;
  logic            q_push;
  logic            q_pop;
  gsg_pkg::cmd_t   q_in;
  gsg_pkg::cmd_t   q_out;
  gsg_pkg::qstat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      scrambling_id <= '0;
      scid_term <= gsg_pkg::SCID_TERM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsg_pkg::CFG_SCRAMBLING_ID: scrambling_id <= cfg_data[15:0];
        gsg_pkg::CFG_SCID_TERM:     scid_term <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  gsg_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .scrambling_id (scrambling_id),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  gsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  gsg_back #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_stat.empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .scrambling_id (scrambling_id),
    .scid_term     (scid_term),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= gsg_pkg::QCNT_W'(gsg_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_out_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!q_stat.empty))
    else $error("output appeared without a queued command");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_qpsk_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.real_part == gsg_pkg::QPSK_POS ||
                    out_data.real_part == gsg_pkg::QPSK_NEG) &&
                   (out_data.imag_part == gsg_pkg::QPSK_POS ||
                    out_data.imag_part == gsg_pkg::QPSK_NEG)))
    else $error("output not a QPSK level");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the DMRS Gold sequence generator with its own pilot predictor.
module tb_top;

  localparam int unsigned WARMUP = gsg_pkg::WARMUP_STEPS_DEFAULT;
  localparam logic signed [15:0] PILOT_POS = 16'sd23167;
  localparam logic signed [15:0] PILOT_NEG = -16'sd23167;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 225;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_THIRD, READY_SPARSE} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  gsg_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gsg_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [gsg_pkg::CFG_IDX_W-1:0] cfg_index = gsg_pkg::CFG_SCRAMBLING_ID;
  logic [gsg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  gsg_pkg::in_t pending_items[$];
  gsg_pkg::out_t expected_pilots[$];

  logic [gsg_pkg::LFSR_W-1:0] x1_state;
  logic [gsg_pkg::LFSR_W-1:0] x2_state;
  logic [15:0] scrambling_id_shadow;
  logic [2:0] scid_term_shadow;

  int n_in = 0;
  int n_out = 0;
  int n_reload = 0;
  int n_err = 0;
  int n_settings = 0;
  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  int ready_tick = 0;
  int idle_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  dmrs_gold_sequence_generator_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void shift_both();
    x1_state = {x1_state[0] ^ x1_state[3], x1_state[gsg_pkg::LFSR_W-1:1]};
    x2_state = {^x2_state[3:0], x2_state[gsg_pkg::LFSR_W-1:1]};
  endfunction

  function automatic void warm_up_both();
    for (int k = 0; k < WARMUP; k++) shift_both();
  endfunction

  function automatic logic take_gold_bit();
    logic b;
    b = x1_state[0] ^ x2_state[0];
    shift_both();
    return b;
  endfunction

  function automatic void reset_pilot_state();
    x1_state = 31'd1;
    x2_state = '0;
    warm_up_both();
    x2_state = '0;
  endfunction

  function automatic void predict_pilot(gsg_pkg::in_t item);
    logic [63:0] c_init;
    gsg_pkg::out_t sym;
    if (item.start_req) begin
      c_init = (64'd1 << gsg_pkg::SHIFT_W)
               * (64'd14 * item.slot_number + item.symbol_index + 64'd1)
               * (64'd2 * scrambling_id_shadow + 64'd1)
               + 64'd2 * scrambling_id_shadow + scid_term_shadow;
      x1_state = 31'd1;
      x2_state = c_init[gsg_pkg::LFSR_W-1:0];
      warm_up_both();
    end
    sym.real_part = take_gold_bit() ? PILOT_NEG : PILOT_POS;
    sym.imag_part = take_gold_bit() ? PILOT_NEG : PILOT_POS;
    expected_pilots.push_back(sym);
  endfunction

  function automatic void queue_item(logic start, logic [7:0] slot, logic [3:0] sym);
    gsg_pkg::in_t item;
    item.start_req = start;
    item.slot_number = slot;
    item.symbol_index = sym;
    pending_items.push_back(item);
  endfunction

  function automatic void queue_random_run(int count);
    int reload_odds;
    logic [7:0] slot;
    logic [3:0] sym;
    reload_odds = $urandom_range(3, 30);
    for (int k = 0; k < count; k++) begin
      slot = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 159));
      sym = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 13));
      queue_item(k == 0 || $urandom_range(1, reload_odds) == 1, slot, sym);
    end
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_pilots.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_both(logic [15:0] id_value, logic [15:0] term_value);
    cfg_we <= 1'b1;
    cfg_index <= gsg_pkg::CFG_SCRAMBLING_ID;
    cfg_data <= id_value;
    @(posedge clk);
    cfg_index <= gsg_pkg::CFG_SCID_TERM;
    cfg_data <= term_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // configuration shadow
  always @(posedge clk) begin
    if (rst) begin
      scrambling_id_shadow <= '0;
      scid_term_shadow <= gsg_pkg::SCID_TERM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gsg_pkg::CFG_SCRAMBLING_ID: scrambling_id_shadow <= cfg_data;
        gsg_pkg::CFG_SCID_TERM: scid_term_shadow <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      reset_pilot_state();
    end else begin
      if (in_valid && in_ready) begin
        predict_pilot(in_data);
        n_in++;
        if (in_data.start_req) n_reload++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      mode_left = 0;
      ready_tick = 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      ready_tick++;
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN: out_ready <= ($urandom_range(0, 1) == 1);
        READY_THIRD: out_ready <= (ready_tick % 3 == 0);
        default: out_ready <= (ready_tick % 16 >= 12);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    gsg_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      n_out++;
      if (expected_pilots.size() == 0) begin
        $error("pilot with nothing expected: real_part %0d imag_part %0d",
               out_data.real_part, out_data.imag_part);
        n_err++;
      end else begin
        want = expected_pilots.pop_front();
        if (out_data.real_part !== want.real_part) begin
          $error("real_part: expected %0d, actual %0d", want.real_part, out_data.real_part);
          n_err++;
        end
        if (out_data.imag_part !== want.imag_part) begin
          $error("imag_part: expected %0d, actual %0d", want.imag_part, out_data.imag_part);
          n_err++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // x1 alone until the first reload
    queue_item(1'b0, 8'hFF, 4'hF);
    queue_item(1'b0, 8'h00, 4'h0);
    queue_item(1'b0, 8'h5A, 4'h6);
    queue_item(1'b1, 8'd0, 4'd0);
    queue_item(1'b0, 8'd0, 4'd0);
    queue_item(1'b1, 8'd159, 4'd13);
    queue_item(1'b0, 8'd159, 4'd13);
    queue_item(1'b1, 8'd255, 4'd15);
    queue_item(1'b1, 8'd200, 4'd14);
    queue_item(1'b0, 8'd3, 4'd2);
    wait_drained();

    write_both(16'hFFFF, 16'hFFFF);
    queue_item(1'b1, 8'd0, 4'd0);
    queue_item(1'b1, 8'd159, 4'd13);
    queue_item(1'b0, 8'd42, 4'd7);
    queue_item(1'b1, 8'd255, 4'd15);
    queue_item(1'b0, 8'd0, 4'd0);
    wait_drained();

    write_both(16'h0000, 16'h0000);
    queue_item(1'b1, 8'd0, 4'd0);
    queue_item(1'b1, 8'd159, 4'd13);
    queue_item(1'b1, 8'd255, 4'd15);
    queue_item(1'b0, 8'd1, 4'd1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: write_both(16'hFFFF, 16'($urandom_range(0, 65535)));
        1: write_both(16'h0000, 16'($urandom_range(0, 65535)));
        default: write_both(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      queue_random_run(PHASE_ITEMS);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("tb_top: %0d pilot symbols checked from %0d input transfers", n_out, n_in);
    $display("tb_top: %0d sequence reloads under %0d register settings", n_reload, n_settings);
    if (n_err == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
